// ===== design/dtq_pkg.sv =====
// Shared constants, codes and control structs for the deadline timer queue.
// Used by dtq_slot_table and deadline_timer_queue_core; no dependencies.
package dtq_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DL_W   = 48;

   localparam logic [15:0] IDLE_WAIT_RST = 16'd10;

   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_ARM    = 2'd1;
   localparam logic [1:0] FUNC_CANCEL = 2'd2;

   localparam logic [1:0] ERR_OK          = 2'd0;
   localparam logic [1:0] ERR_ARM_ARMED   = 2'd1;
   localparam logic [1:0] ERR_CANCEL_IDLE = 2'd2;

   localparam logic KIND_FIRE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [DL_W-1:0]   wr_data;
      logic              clr_en;
      logic [SLOT_W-1:0] clr_addr;
      logic [SLOT_W-1:0] sel_addr;
      logic              scan_start;
      logic              scan_step;
   } dtq_tbl_ctrl_type;

   typedef struct packed {
      logic              sel_armed;
      logic              last_issue;
      logic              found;
      logic [SLOT_W-1:0] best_slot;
      logic [DL_W-1:0]   best_dl;
   } dtq_tbl_stat_type;

endpackage

// ===== design/dtq_slot_table.sv =====
// Slot table: deadline memory, armed flags and the earliest-deadline scanner.
// Depends on dtq_pkg.
module dtq_slot_table (
   input  logic                      clock,
   input  logic                      reset,
   input  dtq_pkg::dtq_tbl_ctrl_type ctrl,
   output dtq_pkg::dtq_tbl_stat_type stat
);

   logic [dtq_pkg::DL_W-1:0]   dl_mem [dtq_pkg::SLOTS];
   logic [dtq_pkg::SLOTS-1:0]  armed_ff, armed_in;
   logic [dtq_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic                       rv_ff;
   logic [dtq_pkg::SLOT_W-1:0] ridx_ff;
   logic [dtq_pkg::DL_W-1:0]   rd_data_ff;
   logic                       found_ff, found_in;
   logic [dtq_pkg::SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [dtq_pkg::DL_W-1:0]   best_dl_ff, best_dl_in;
   logic                       take;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         dl_mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data_ff <= dl_mem[idx_ff];
      ridx_ff    <= idx_ff;
   end

   always_comb begin
      armed_in = armed_ff;
      if (ctrl.wr_en) begin
         armed_in[ctrl.wr_addr] = 1'b1;
      end
      if (ctrl.clr_en) begin
         armed_in[ctrl.clr_addr] = 1'b0;
      end
   end

   assign take = rv_ff && armed_ff[ridx_ff] && (!found_ff || (rd_data_ff < best_dl_ff));

   always_comb begin
      idx_in       = idx_ff;
      found_in     = found_ff;
      best_slot_in = best_slot_ff;
      best_dl_in   = best_dl_ff;
      if (ctrl.scan_start) begin
         idx_in   = '0;
         found_in = 1'b0;
      end else begin
         if (ctrl.scan_step) begin
            idx_in = idx_ff + 1'b1;
         end
         if (take) begin
            found_in     = 1'b1;
            best_slot_in = ridx_ff;
            best_dl_in   = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         idx_ff   <= '0;
         rv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
         idx_ff   <= idx_in;
         rv_ff    <= ctrl.scan_step && !ctrl.scan_start;
         found_ff <= found_in;
      end
      best_slot_ff <= best_slot_in;
      best_dl_ff   <= best_dl_in;
   end

   assign stat.sel_armed  = armed_ff[ctrl.sel_addr];
   assign stat.last_issue = (idx_ff == dtq_pkg::SLOT_W'(dtq_pkg::SLOTS - 1));
   assign stat.found      = found_ff;
   assign stat.best_slot  = best_slot_ff;
   assign stat.best_dl    = best_dl_ff;

endmodule

// ===== design/deadline_timer_queue_core.sv =====
// Top level of the deadline timer queue: item sequencer, ms counter, result register.
// Depends on dtq_pkg and dtq_slot_table.
//
// The block keeps a 48-bit millisecond counter and a table of timer slots whose
// deadlines live in a one-port-read synchronous memory. One item is worked at a
// time. Every item ends with one scan of the table that reads one slot per cycle.
// A tick that fires k timers runs k + 1 scans, one before each fire and one
// before its status result. A stall on the result channel holds the item until
// the result can be written. The result register lets the next item transfer
// while the last status still waits to be taken.
module deadline_timer_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_elapse,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [3:0]  rsp_fired_slot,
   output logic [31:0] rsp_next_wait,
   output logic [1:0]  rsp_error,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [dtq_pkg::DL_W-1:0]   now_ff, now_in;
   logic [15:0]                idle_ff;
   logic [1:0]                 func_ff;
   logic [3:0]                 slot_ff;
   logic [31:0]                elapse_ff;
   logic [1:0]                 err_ff, err_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [3:0]                 rsp_slot_ff, rsp_slot_in;
   logic [31:0]                rsp_wait_ff, rsp_wait_in;
   logic [1:0]                 rsp_err_ff, rsp_err_in;
   logic                       rsp_last_ff, rsp_last_in;

   dtq_pkg::dtq_tbl_ctrl_type  ctrl;
   dtq_pkg::dtq_tbl_stat_type  stat;

   logic                       accept;
   logic                       out_free;
   logic                       slot_ok;
   logic                       due;
   logic [dtq_pkg::DL_W-1:0]   diff;
   logic [31:0]                wait_val;

   dtq_slot_table u_table (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_ok   = ({5'd0, slot_ff} < 9'(dtq_pkg::SLOTS));
   assign due       = stat.found && (stat.best_dl <= now_ff);
   assign diff      = stat.best_dl - now_ff;

   always_comb begin
      if (!stat.found) begin
         wait_val = {16'd0, idle_ff};
      end else if (stat.best_dl <= now_ff) begin
         wait_val = '0;
      end else if (|diff[dtq_pkg::DL_W-1:32]) begin
         wait_val = '1;
      end else begin
         wait_val = diff[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;

      ctrl.wr_en      = 1'b0;
      ctrl.wr_addr    = dtq_pkg::SLOT_W'(slot_ff);
      ctrl.wr_data    = now_ff + {16'd0, elapse_ff};
      ctrl.clr_en     = 1'b0;
      ctrl.clr_addr   = dtq_pkg::SLOT_W'(slot_ff);
      ctrl.sel_addr   = dtq_pkg::SLOT_W'(slot_ff);
      ctrl.scan_start = 1'b0;
      ctrl.scan_step  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in   = dtq_pkg::ERR_OK;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (func_ff)
               dtq_pkg::FUNC_TICK: begin
                  now_in = now_ff + 1'b1;
               end
               dtq_pkg::FUNC_ARM: begin
                  if (slot_ok) begin
                     if (stat.sel_armed) begin
                        err_in = dtq_pkg::ERR_ARM_ARMED;
                     end else begin
                        ctrl.wr_en = 1'b1;
                     end
                  end
               end
               dtq_pkg::FUNC_CANCEL: begin
                  if (slot_ok) begin
                     if (stat.sel_armed) begin
                        ctrl.clr_en = 1'b1;
                     end else begin
                        err_in = dtq_pkg::ERR_CANCEL_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
            ctrl.scan_start = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            if (stat.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if ((func_ff == dtq_pkg::FUNC_TICK) && due) begin
                  rsp_kind_in     = dtq_pkg::KIND_FIRE;
                  rsp_slot_in     = 4'(stat.best_slot);
                  rsp_wait_in     = '0;
                  rsp_err_in      = dtq_pkg::ERR_OK;
                  rsp_last_in     = 1'b0;
                  ctrl.clr_en     = 1'b1;
                  ctrl.clr_addr   = stat.best_slot;
                  ctrl.scan_start = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  rsp_kind_in = dtq_pkg::KIND_STATUS;
                  rsp_slot_in = '0;
                  rsp_wait_in = wait_val;
                  rsp_err_in  = err_ff;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         idle_ff      <= dtq_pkg::IDLE_WAIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            idle_ff <= csr_wr_data;
         end
      end
      if (accept) begin
         func_ff   <= req_func;
         slot_ff   <= req_slot;
         elapse_ff <= req_elapse;
      end
      err_ff      <= err_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_next_wait  = rsp_wait_ff;
   assign rsp_error      = rsp_err_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== tb/sv/tb_deadline_timer_queue_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for deadline_timer_queue_core: timer items and idle-wait
// CSR writes in, every fire and status transfer predicted and checked in order.
// Depends on dtq_pkg and the deadline_timer_queue_core RTL.
module tb_deadline_timer_queue_core;

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         RANDOM_ITEMS = 205;
   localparam int         PHASES       = 5;
   localparam int         DRAIN_CYCLES = 40;

   typedef struct packed {
      logic        kind;
      logic [3:0]  fired_slot;
      logic [31:0] next_wait;
      logic [1:0]  err_code;
      logic        last_flag;
   } timer_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func    = dtq_pkg::FUNC_TICK;
   logic [3:0]  req_slot    = '0;
   logic [31:0] req_elapse  = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_kind;
   logic [3:0]  rsp_fired_slot;
   logic [31:0] rsp_next_wait;
   logic [1:0]  rsp_error;
   logic        rsp_last;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   logic [dtq_pkg::DL_W-1:0] now_ms;
   logic [dtq_pkg::DL_W-1:0] slot_deadline [dtq_pkg::SLOTS];
   logic                     slot_armed    [dtq_pkg::SLOTS];
   logic [15:0]              idle_wait_ms;

   timer_result_type pending_results[$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int items_sent     = 0;
   int config_writes  = 0;
   int fires_checked  = 0;
   int max_fires      = 0;
   int arm_errors     = 0;
   int cancel_errors  = 0;
   int burst_left     = 0;
   int stall_mode     = 0;

   deadline_timer_queue_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_slot       (req_slot),
      .req_elapse     (req_elapse),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_next_wait  (rsp_next_wait),
      .rsp_error      (rsp_error),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void reset_timer_model();
      now_ms       = '0;
      idle_wait_ms = dtq_pkg::IDLE_WAIT_RST;
      for (int i = 0; i < dtq_pkg::SLOTS; i++) begin
         slot_armed[i]    = 1'b0;
         slot_deadline[i] = '0;
      end
   endfunction

   function automatic int earliest_slot();
      int best;
      best = -1;
      for (int i = 0; i < dtq_pkg::SLOTS; i++) begin
         if (slot_armed[i] && (best < 0 || slot_deadline[i] < slot_deadline[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic int pick_armed_slot(input int fallback);
      int start;
      start = $urandom_range(0, dtq_pkg::SLOTS - 1);
      for (int i = 0; i < dtq_pkg::SLOTS; i++) begin
         if (slot_armed[(start + i) % dtq_pkg::SLOTS])
            return (start + i) % dtq_pkg::SLOTS;
      end
      return fallback;
   endfunction

   // Advance the timer table by one item and queue the transfers it causes.
   function automatic void predict_timer_results(input logic [1:0] func,
                                                 input logic [3:0] slot,
                                                 input logic [31:0] elapse);
      timer_result_type         res;
      logic [1:0]               err;
      logic [dtq_pkg::DL_W-1:0] gap_ms;
      logic [31:0]              wait_value;
      int                       e;
      int                       n;
      err = dtq_pkg::ERR_OK;
      n   = 0;
      case (func)
         dtq_pkg::FUNC_TICK: begin
            now_ms = now_ms + 1'b1;
            while (n < dtq_pkg::SLOTS) begin
               e = earliest_slot();
               if (e < 0 || slot_deadline[e] > now_ms)
                  break;
               slot_armed[e] = 1'b0;
               res = '{kind: dtq_pkg::KIND_FIRE, fired_slot: 4'(e), next_wait: '0,
                       err_code: dtq_pkg::ERR_OK, last_flag: 1'b0};
               pending_results.push_back(res);
               n++;
            end
            if (n > max_fires)
               max_fires = n;
         end
         dtq_pkg::FUNC_ARM: begin
            if (slot < dtq_pkg::SLOTS) begin
               if (slot_armed[slot]) begin
                  err = dtq_pkg::ERR_ARM_ARMED;
                  arm_errors++;
               end else begin
                  slot_deadline[slot] = now_ms + dtq_pkg::DL_W'(elapse);
                  slot_armed[slot]    = 1'b1;
               end
            end
         end
         dtq_pkg::FUNC_CANCEL: begin
            if (slot < dtq_pkg::SLOTS) begin
               if (slot_armed[slot]) begin
                  slot_armed[slot] = 1'b0;
               end else begin
                  err = dtq_pkg::ERR_CANCEL_IDLE;
                  cancel_errors++;
               end
            end
         end
         default: ;
      endcase
      e = earliest_slot();
      if (e < 0) begin
         wait_value = {16'b0, idle_wait_ms};
      end else if (slot_deadline[e] <= now_ms) begin
         wait_value = '0;
      end else begin
         gap_ms     = slot_deadline[e] - now_ms;
         wait_value = (gap_ms > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap_ms[31:0];
      end
      res = '{kind: dtq_pkg::KIND_STATUS, fired_slot: '0, next_wait: wait_value,
              err_code: err, last_flag: 1'b1};
      pending_results.push_back(res);
   endfunction

   task automatic send_item(input logic [1:0] func, input logic [3:0] slot,
                            input logic [31:0] elapse);
      int gap;
      req_valid  <= 1'b1;
      req_func   <= func;
      req_slot   <= slot;
      req_elapse <= elapse;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_timer_results(func, slot, elapse);
      items_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_idle_wait(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      idle_wait_ms  = value;
      config_writes++;
   endtask

   task automatic test_reset_state();
      send_item(FUNC_UNUSED, 4'd15, 32'hFFFF_FFFF);
      send_item(dtq_pkg::FUNC_CANCEL, 4'd0, 32'h0);
      send_item(dtq_pkg::FUNC_TICK, 4'd0, 32'h0);
      wait_results_drained();
   endtask

   task automatic test_arm_cancel_errors();
      write_idle_wait(16'hFFFF);
      send_item(dtq_pkg::FUNC_ARM, 4'd15, 32'hFFFF_FFFF);
      send_item(dtq_pkg::FUNC_ARM, 4'd15, 32'h0);
      send_item(dtq_pkg::FUNC_CANCEL, 4'd15, 32'hFFFF_FFFF);
      send_item(dtq_pkg::FUNC_CANCEL, 4'd15, 32'h0);
      wait_results_drained();
   endtask

   // Odd slots fall due now and even slots on the next tick: one tick fires all,
   // odd slots first, ties broken by slot number.
   task automatic test_fire_all_slots();
      write_idle_wait(16'h0000);
      for (int i = 0; i < dtq_pkg::SLOTS; i++)
         send_item(dtq_pkg::FUNC_ARM, 4'(i), (i % 2 == 1) ? 32'd0 : 32'd1);
      send_item(dtq_pkg::FUNC_TICK, 4'd7, 32'h0);
      wait_results_drained();
   endtask

   task automatic test_random_traffic();
      int          pick;
      logic [1:0]  func;
      logic [3:0]  slot;
      logic [31:0] elapse;
      logic [15:0] idle_value;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       idle_value = 16'hFFFF;
            1:       idle_value = 16'h0000;
            default: idle_value = 16'($urandom_range(0, 65535));
         endcase
         write_idle_wait(idle_value);
         for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
            pick   = $urandom_range(0, 99);
            slot   = 4'($urandom_range(0, dtq_pkg::SLOTS - 1));
            elapse = $urandom();
            if (pick < 45) begin
               func = dtq_pkg::FUNC_TICK;
            end else if (pick < 75) begin
               func = dtq_pkg::FUNC_ARM;
               if (pick < 68)
                  elapse = $urandom_range(0, 12);
               else if (pick < 70)
                  elapse = 32'hFFFF_FFFF;
            end else if (pick < 95) begin
               func = dtq_pkg::FUNC_CANCEL;
               if (pick < 90)
                  slot = 4'(pick_armed_slot(slot));
            end else begin
               func = FUNC_UNUSED;
            end
            send_item(func, slot, elapse);
         end
         wait_results_drained();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      timer_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer kind %0d slot %0d wait %0h error %0d last %0d",
                     $time, rsp_kind, rsp_fired_slot, rsp_next_wait, rsp_error, rsp_last);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("fired_slot", want.fired_slot, rsp_fired_slot);
            check_field("next_wait", want.next_wait, rsp_next_wait);
            check_field("error", want.err_code, rsp_error);
            check_field("last", want.last_flag, rsp_last);
            if (rsp_kind == dtq_pkg::KIND_FIRE)
               fires_checked++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset_timer_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_arm_cancel_errors();
      test_fire_all_slots();
      test_random_traffic();
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items over %0d idle-wait settings; %0d timer fires checked,",
               items_sent, config_writes + 1, fires_checked);
      $display("%0d on one tick. Arms of armed slots: %0d, cancels of idle slots: %0d.",
               max_fires, arm_errors, cancel_errors);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0t: %0d mismatches, %0d results still expected",
                  $time, mismatch_count, pending_results.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
